// ===== rtl/tors_pkg.sv =====
`timescale 1ns / 1ps
// tors_pkg: shared types and constants for the time-of-day relay schedule table
// used by tors_cell, time_of_day_relay_schedule_table and tors_checker
package tors_pkg;

  // default table depth, handed to the top level parameter
  localparam int MAX_ENTRIES_DEF = 16;
  // days in a week, one mask bit each
  localparam int DAYS_PER_WEEK   = 7;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // control states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  // one schedule entry as held in a cell
  typedef struct packed {
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic                     switch_on;
    logic                     every_day;
    logic [DAYS_PER_WEEK-1:0] weekday_mask;
  } entry_t;

  // input transfer payload
  typedef struct packed {
    kind_t                    kind;
    logic [4:0]               slot_id;
    logic [4:0]               at_hour;
    logic [5:0]               at_minute;
    logic                     switch_on;
    logic                     every_day;
    logic [DAYS_PER_WEEK-1:0] weekday_mask;
    logic [2:0]               weekday;
    logic [4:0]               day_of_month;
    logic [3:0]               month_number;
    logic [11:0]              year_number;
  } in_item_t;

  // result transfer payload
  typedef struct packed {
    status_t    status;
    logic [4:0] assigned_id;
    logic       relay_on;
    logic       relay_written;
    logic [4:0] entry_count;
  } out_item_t;

  // per-cell control: load a new entry or take the neighbor's entry
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/tors_cell.sv =====
`timescale 1ns / 1ps
// tors_cell: one slot of the schedule chain, holds a single entry
// depends on tors_pkg for the entry and control types
module tors_cell (
  input  logic                clk,
  input  tors_pkg::cell_ctrl_t ctrl,
  input  tors_pkg::entry_t    wdata,
  input  tors_pkg::entry_t    neighbor,
  output tors_pkg::entry_t    entry_o
);
  import tors_pkg::*;

  entry_t data_r;

  // load a written entry, or take the next cell's entry on a shift
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data_r <= wdata;
    end else if (ctrl.shift) begin
      data_r <= neighbor;
    end
  end

  assign entry_o = data_r;

endmodule

// ===== rtl/time_of_day_relay_schedule_table.sv =====
`timescale 1ns / 1ps
// Time-of-day relay schedule table: usage notes
// Input channel: drive in_data and raise start; a transfer happens at a rising
// edge with start high and busy low. kind selects tick, add, update or delete.
// Result channel: out_valid is high for exactly one cycle with out_data; the
// receiver takes it at the edge that ends that cycle and cannot stall it.
// Add, update, delete and any tick that does not scan give their result in
// the cycle after the transfer and busy stays low, so one item per cycle is
// possible. A tick whose time differs from the last recorded one (and is not
// the first after reset) scans the table: the entries sit in a chain of
// MAX_ENTRIES cells that rotates one place per cycle past the compare at cell
// zero, so busy stays high until every cell has passed the compare, and the
// result follows the scan; no new item is taken while busy is high.
// Delete shifts all the later cells down together at the transfer edge.
// Reset (rst_n low, synchronous) empties the table, turns the relay off and
// forgets the last tick time; the cell contents are not cleared.
// depends on tors_pkg, instantiates tors_cell
module time_of_day_relay_schedule_table #(
  parameter int MAX_ENTRIES = tors_pkg::MAX_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tors_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output tors_pkg::out_item_t  out_data
);
  import tors_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = (CW > 5) ? CW : 5;

  // control and status registers
  state_t        state_r, state_nxt;
  logic [IW-1:0] step_r, step_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          relay_r, relay_nxt;
  logic          written_r, written_nxt;
  logic          seen_r, seen_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;
  in_item_t      tick_r;
  logic [5:0]    last_min_r;
  logic [4:0]    last_hour_r;
  logic [4:0]    last_day_r;
  logic [3:0]    last_month_r;
  logic [11:0]   last_year_r;

  // chain signals
  entry_t        cells   [MAX_ENTRIES];
  cell_ctrl_t    ctrl    [MAX_ENTRIES];
  entry_t        wr_entry;
  entry_t        head;

  logic                 accept;
  logic                 changed;
  logic                 full;
  logic                 slot_bad;
  logic [SW-1:0]        slot_w;
  logic [IW-1:0]        slot_idx;
  logic [CW-1:0]        count_inc;
  logic                 do_add, do_upd, do_del;
  logic                 scan_start, record;
  logic                 hit;
  logic [DAYS_PER_WEEK:0] day_bits;

  assign busy   = (state_r == S_SCAN);
  assign accept = start && !busy;

  // entry built from the input transfer
  assign wr_entry = '{hour: in_data.at_hour, minute: in_data.at_minute,
                      switch_on: in_data.switch_on, every_day: in_data.every_day,
                      weekday_mask: in_data.weekday_mask};

  // slot and fill checks
  assign slot_w    = SW'(in_data.slot_id);
  assign slot_bad  = (slot_w == '0) || (slot_w > SW'(count_r));
  assign slot_idx  = IW'(slot_w - SW'(1));
  assign full      = (count_r >= CW'(MAX_ENTRIES));
  assign count_inc = count_r + CW'(1);

  assign do_add = accept && (in_data.kind == KIND_ADD) && !full;
  assign do_upd = accept && (in_data.kind == KIND_UPDATE) && !slot_bad;
  assign do_del = accept && (in_data.kind == KIND_DELETE) && !slot_bad;

  // tick time compare against the last recorded tick
  assign changed = (in_data.at_minute != last_min_r) || (in_data.at_hour != last_hour_r) ||
                   (in_data.day_of_month != last_day_r) ||
                   (in_data.month_number != last_month_r) ||
                   (in_data.year_number != last_year_r);
  assign scan_start = accept && (in_data.kind == KIND_TICK) && seen_r && changed;
  assign record     = accept && (in_data.kind == KIND_TICK) && (!seen_r || changed);

  // the chain of cells, each handing its entry to the one below
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign ctrl[i].load  = (do_add && (count_r == CW'(i))) ||
                           (do_upd && (slot_idx == IW'(i)));
    assign ctrl[i].shift = busy || (do_del && (IW'(i) >= slot_idx));

    tors_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .wdata    (wr_entry),
      .neighbor (cells[(i + 1) % MAX_ENTRIES]),
      .entry_o  (cells[i])
    );
  end

  // match at the head of the chain during a scan
  assign head     = cells[0];
  assign day_bits = {1'b0, head.weekday_mask};
  assign hit = busy && (CW'(step_r) < count_r) &&
               (head.hour == tick_r.at_hour) && (head.minute == tick_r.at_minute) &&
               (head.every_day || day_bits[tick_r.weekday]);

  // next state and result
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    relay_nxt     = relay_r;
    written_nxt   = written_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.status        = ST_DONE;
          out_nxt.assigned_id   = '0;
          out_nxt.relay_on      = relay_r;
          out_nxt.relay_written = 1'b0;
          out_valid_nxt         = 1'b1;
          unique case (in_data.kind)
            KIND_TICK: begin
              if (scan_start) begin
                state_nxt     = S_SCAN;
                step_nxt      = '0;
                written_nxt   = 1'b0;
                out_valid_nxt = 1'b0;
              end
            end
            KIND_ADD: begin
              if (full) begin
                out_nxt.status = ST_FULL;
              end else begin
                count_nxt           = count_inc;
                out_nxt.assigned_id = 5'(count_inc);
              end
            end
            KIND_UPDATE: begin
              if (slot_bad) begin
                out_nxt.status = ST_NOT_FOUND;
              end
            end
            KIND_DELETE: begin
              if (slot_bad) begin
                out_nxt.status = ST_NOT_FOUND;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            default: begin
              out_nxt.status = ST_DONE;
            end
          endcase
          out_nxt.entry_count = 5'(count_nxt);
        end
      end
      S_SCAN: begin
        if (hit) begin
          relay_nxt   = head.switch_on;
          written_nxt = 1'b1;
        end
        step_nxt = step_r + IW'(1);
        if (step_r == IW'(MAX_ENTRIES - 1)) begin
          state_nxt             = S_IDLE;
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ST_DONE;
          out_nxt.assigned_id   = '0;
          out_nxt.relay_on      = relay_nxt;
          out_nxt.relay_written = written_nxt;
          out_nxt.entry_count   = 5'(count_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    seen_nxt = seen_r || record;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      relay_r     <= 1'b0;
      written_r   <= 1'b0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      last_min_r   <= '0;
      last_hour_r  <= '0;
      last_day_r   <= '0;
      last_month_r <= '0;
      last_year_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      relay_r     <= relay_nxt;
      written_r   <= written_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (record) begin
        last_min_r   <= in_data.at_minute;
        last_hour_r  <= in_data.at_hour;
        last_day_r   <= in_data.day_of_month;
        last_month_r <= in_data.month_number;
        last_year_r  <= in_data.year_number;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (scan_start) begin
      tick_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/tors_checker.sv =====
`timescale 1ns / 1ps
// tors_port_props: port-level checks on the schedule table, bound to the top level
// depends on tors_pkg
module tors_port_props (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tors_pkg::in_item_t  in_data,
  input logic                out_valid,
  input tors_pkg::out_item_t out_data
);
  import tors_pkg::*;

  // after a reset edge the block is idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // a result never shows while a scan is running
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe during scan");

  // table edits answer in the next cycle
  a_edit_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind != KIND_TICK |=> out_valid)
    else $error("edit result missing");

  // a tick either answers at once or starts a scan
  a_tick_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.kind == KIND_TICK |=> out_valid || busy)
    else $error("tick neither answered nor scanning");

  // a rejected edit assigns no slot and writes no relay
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |->
      out_data.assigned_id == 5'd0 && !out_data.relay_written)
    else $error("rejected item with side results");

endmodule

bind time_of_day_relay_schedule_table tors_port_props u_tors_port_props (.*);

// ===== sim/tors_checker.sv =====
`timescale 1ns / 1ps
// tors_checker: watches the request and result transfers of the relay schedule table,
// keeps its own copy of the table and relay, and compares every result field by field
// depends on tors_pkg
module tors_checker #(
  parameter int MAX_ENTRIES = tors_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  tors_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  tors_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen,
  output int                  relay_writes,
  output int                  full_answers,
  output int                  missing_answers
);
  import tors_pkg::*;

  // shadow of the schedule table and relay
  entry_t      sched [MAX_ENTRIES];
  int          held;
  logic [5:0]  last_min;
  logic [4:0]  last_hr;
  logic [4:0]  last_day;
  logic [3:0]  last_mon;
  logic [11:0] last_yr;
  logic        time_known;
  logic        relay;

  out_item_t   expected_results [$];
  out_item_t   want;
  int          err_cnt;
  int          result_cnt;
  int          write_cnt;
  int          full_cnt;
  int          missing_cnt;

  // apply one request to the shadow table and return the answer it gives
  function automatic out_item_t predict_schedule(in_item_t req);
    out_item_t res;
    entry_t    ent;
    logic      moved;
    logic      today;
    res = '0;
    res.status = ST_DONE;
    ent = {req.at_hour, req.at_minute, req.switch_on, req.every_day, req.weekday_mask};
    case (req.kind)
      KIND_TICK: begin
        moved = (req.at_minute != last_min) || (req.at_hour != last_hr) ||
                (req.day_of_month != last_day) || (req.month_number != last_mon) ||
                (req.year_number != last_yr);
        // scan in slot order, so the last matching entry sets the relay
        if (time_known && moved) begin
          for (int i = 0; i < held; i++) begin
            today = sched[i].every_day ||
                    ((req.weekday < DAYS_PER_WEEK) ? sched[i].weekday_mask[req.weekday] : 1'b0);
            if (sched[i].hour == req.at_hour && sched[i].minute == req.at_minute && today) begin
              relay = sched[i].switch_on;
              res.relay_written = 1'b1;
            end
          end
        end
        if (!time_known || moved) begin
          last_min   = req.at_minute;
          last_hr    = req.at_hour;
          last_day   = req.day_of_month;
          last_mon   = req.month_number;
          last_yr    = req.year_number;
          time_known = 1'b1;
        end
      end
      KIND_ADD: begin
        if (held >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          sched[held] = ent;
          held++;
          res.assigned_id = held[4:0];
        end
      end
      KIND_UPDATE: begin
        if (req.slot_id == 0 || int'(req.slot_id) > held) begin
          res.status = ST_NOT_FOUND;
        end else begin
          sched[int'(req.slot_id) - 1] = ent;
        end
      end
      default: begin
        // delete closes the gap so the slots stay dense
        if (req.slot_id == 0 || int'(req.slot_id) > held) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = int'(req.slot_id) - 1; i + 1 < held; i++) sched[i] = sched[i + 1];
          held--;
        end
      end
    endcase
    res.relay_on = relay;
    res.entry_count = held[4:0];
    return res;
  endfunction

  task automatic check_field(string label, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns tors_checker: %s expected %0d actual %0d", $time, label, exp_val,
               act_val);
      err_cnt++;
    end
  endtask

  // predict on every request transfer, compare on every result strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      held       = 0;
      last_min   = '0;
      last_hr    = '0;
      last_day   = '0;
      last_mon   = '0;
      last_yr    = '0;
      time_known = 1'b0;
      relay      = 1'b0;
      expected_results.delete();
    end else begin
      if (start && !busy) expected_results.push_back(predict_schedule(in_data));
      if (out_valid) begin
        result_cnt++;
        if (expected_results.size() == 0) begin
          $display("%0t ns tors_checker: result with nothing expected, actual %p", $time,
                   out_data);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(out_data.status));
          check_field("assigned_id", int'(want.assigned_id), int'(out_data.assigned_id));
          check_field("relay_on", int'(want.relay_on), int'(out_data.relay_on));
          check_field("relay_written", int'(want.relay_written),
                      int'(out_data.relay_written));
          check_field("entry_count", int'(want.entry_count), int'(out_data.entry_count));
          if (want.relay_written) write_cnt++;
          if (want.status == ST_FULL) full_cnt++;
          if (want.status == ST_NOT_FOUND) missing_cnt++;
        end
      end
    end
    mismatches      <= err_cnt;
    pending         <= expected_results.size();
    results_seen    <= result_cnt;
    relay_writes    <= write_cnt;
    full_answers    <= full_cnt;
    missing_answers <= missing_cnt;
  end

endmodule

// ===== sim/time_of_day_relay_schedule_table_tb.sv =====
`timescale 1ns / 1ps
// time_of_day_relay_schedule_table_tb: drives ticks and table edits into the schedule table
// and gives the verdict; depends on tors_pkg, the block and tors_checker
module time_of_day_relay_schedule_table_tb;
  import tors_pkg::*;

  localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  int        mismatches;
  int        pending;
  int        results_seen;
  int        relay_writes;
  int        full_answers;
  int        missing_answers;
  int        quiet_cycles;
  int        idle_pct;
  in_item_t  last_tick;

  // per phase: share of adds, deletes, updates and sender idling
  int        add_mix  [3] = '{40, 15, 30};
  int        del_mix  [3] = '{10, 35, 25};
  int        upd_mix  [3] = '{15, 15, 15};
  int        idle_mix [3] = '{22, 55, 0};

  always #10 clk = ~clk;

  time_of_day_relay_schedule_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  tors_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .results_seen   (results_seen),
    .relay_writes   (relay_writes),
    .full_answers   (full_answers),
    .missing_answers(missing_answers)
  );

  // watchdog: give up when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("time_of_day_relay_schedule_table_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t noise_item();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return in_item_t'(r[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t tick_item(int hr, int mn, int wd, int dy, int mo, int yr);
    in_item_t it;
    it = noise_item();
    it.kind         = KIND_TICK;
    it.at_hour      = 5'(hr);
    it.at_minute    = 6'(mn);
    it.weekday      = 3'(wd);
    it.day_of_month = 5'(dy);
    it.month_number = 4'(mo);
    it.year_number  = 12'(yr);
    return it;
  endfunction

  function automatic in_item_t entry_item(kind_t k, int slot, int hr, int mn, logic on,
                                          logic ed, logic [6:0] mask);
    in_item_t it;
    it = noise_item();
    it.kind         = k;
    it.slot_id      = 5'(slot);
    it.at_hour      = 5'(hr);
    it.at_minute    = 6'(mn);
    it.switch_on    = on;
    it.every_day    = ed;
    it.weekday_mask = mask;
    return it;
  endfunction

  // random request; times mostly from a small pool so ticks hit stored entries
  function automatic in_item_t random_request(int add_pct, int del_pct, int upd_pct);
    in_item_t it;
    int       roll;
    it = noise_item();
    roll = $urandom_range(99);
    if (roll < add_pct) it.kind = KIND_ADD;
    else if (roll < add_pct + del_pct) it.kind = KIND_DELETE;
    else if (roll < add_pct + del_pct + upd_pct) it.kind = KIND_UPDATE;
    else it.kind = KIND_TICK;
    it.at_hour   = 5'(($urandom_range(99) < 80) ? $urandom_range(2) : $urandom_range(31));
    it.at_minute = 6'(($urandom_range(99) < 80) ? $urandom_range(2) : $urandom_range(63));
    it.slot_id   = 5'(($urandom_range(99) < 85) ? $urandom_range(17) : $urandom_range(31));
    if (it.kind == KIND_TICK) begin
      it.weekday = 3'($urandom_range(7));
      // sometimes repeat the last time so the tick changes nothing
      if ($urandom_range(99) < 15) begin
        it.at_hour      = last_tick.at_hour;
        it.at_minute    = last_tick.at_minute;
        it.day_of_month = last_tick.day_of_month;
        it.month_number = last_tick.month_number;
        it.year_number  = last_tick.year_number;
      end
    end else begin
      it.every_day = ($urandom_range(99) < 30);
    end
    return it;
  endfunction

  // one request transfer, with random sender gaps in front of it
  task automatic send_item(input in_item_t req);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      in_data <= noise_item();
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    if (req.kind == KIND_TICK) last_tick = req;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    idle_pct  = 0;
    last_tick = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first tick only records, misses on an empty table
    send_item(tick_item(0, 0, 0, 0, 0, 0));
    send_item(entry_item(KIND_DELETE, 1, 0, 0, 1'b0, 1'b0, 7'h00));
    send_item(entry_item(KIND_UPDATE, 0, 0, 0, 1'b0, 1'b0, 7'h00));
    // entries at the field extremes
    send_item(entry_item(KIND_ADD, 0, 0, 0, 1'b1, 1'b1, 7'h00));
    send_item(entry_item(KIND_ADD, 0, 23, 59, 1'b0, 1'b0, 7'h01));
    send_item(entry_item(KIND_ADD, 0, 31, 63, 1'b1, 1'b0, 7'h7f));
    // same time as the first tick: no scan even though an entry matches
    send_item(tick_item(0, 0, 3, 0, 0, 0));
    send_item(tick_item(0, 0, 7, 1, 0, 0));
    send_item(tick_item(23, 59, 0, 1, 1, 2024));
    // weekday seven: a full mask without every-day does not match
    send_item(tick_item(31, 63, 7, 31, 15, 4095));
    send_item(entry_item(KIND_UPDATE, 3, 31, 63, 1'b0, 1'b1, 7'h00));
    send_item(entry_item(KIND_UPDATE, 4, 1, 1, 1'b1, 1'b1, 7'h7f));
    send_item(entry_item(KIND_DELETE, 31, 0, 0, 1'b0, 1'b0, 7'h00));
    send_item(entry_item(KIND_DELETE, 1, 0, 0, 1'b0, 1'b0, 7'h00));
    send_item(tick_item(31, 63, 7, 30, 14, 4093));
    // two matches: the later slot wins
    send_item(entry_item(KIND_ADD, 0, 23, 59, 1'b1, 1'b1, 7'h00));
    send_item(tick_item(23, 59, 0, 31, 12, 100));
    // fill the table, overflow it, drop the last slot
    repeat (MAX_ENTRIES - 3) begin
      send_item(entry_item(KIND_ADD, 0, $urandom_range(2), $urandom_range(2),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           7'($urandom_range(127))));
    end
    send_item(entry_item(KIND_ADD, 0, 5, 5, 1'b1, 1'b1, 7'h7f));
    send_item(entry_item(KIND_DELETE, MAX_ENTRIES, 0, 0, 1'b0, 1'b0, 7'h00));

    // random phases: add-heavy, delete-heavy, balanced
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = idle_mix[ph];
      repeat (RANDOM_ITEMS / 3) send_item(random_request(add_mix[ph], del_mix[ph], upd_mix[ph]));
    end
    start <= 1'b0;

    // drain the outstanding results, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d results: %0d relay writes,", results_seen, relay_writes);
    $display("  %0d full-table and %0d missing-slot answers", full_answers, missing_answers);
    if (mismatches == 0) begin
      $display("time_of_day_relay_schedule_table_tb: clean");
    end else begin
      $display("time_of_day_relay_schedule_table_tb: errors");
    end
    $finish;
  end

endmodule
